FILE: design/assert_macros.svh
// Assertion macros used by the slot allocator sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define SARD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("slot allocator assertion failed");

// Checked on every rising edge, reset included.
`define SARD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("slot allocator assertion failed");

`endif

FILE: design/sard_pkg.sv
// Types and constants of the slot allocator with reuse delay.
package sard_pkg;

  localparam int SLOT_W     = 9;
  localparam int HW_W       = 10;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int RST_FIRST_SLOT    = 33;
  localparam int RST_GRACE_MS      = 2000;
  localparam int RST_QUARANTINE_MS = 500;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE_MS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARANTINE_MS = 2'd2;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot_index;
    logic [TIME_W-1:0] now_ms;
  } sard_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              table_full;
    logic [HW_W-1:0]   high_water;
  } sard_out_t;

  typedef struct packed {
    logic [SLOT_W-1:0] first_slot;
    logic [MS_W-1:0]   grace_ms;
    logic [MS_W-1:0]   quarantine_ms;
  } sard_cfg_t;

  // write enables and the busy write bit towards the two slot memories
  typedef struct packed {
    logic busy_we;
    logic busy_wd;
    logic stamp_we;
  } sard_mem_ctl_t;

endpackage

FILE: design/sard_ram.sv
// Generic single-port RAM with registered read.
module sard_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sard_cfg.sv
// Configuration registers of the slot allocator.
module sard_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sard_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sard_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output sard_pkg::sard_cfg_t                 cfg_o
);
  import sard_pkg::*;

  sard_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_SLOT:    cfg_d.first_slot    = cfg_wdata_i[SLOT_W-1:0];
        CFG_GRACE_MS:      cfg_d.grace_ms      = cfg_wdata_i[MS_W-1:0];
        CFG_QUARANTINE_MS: cfg_d.quarantine_ms = cfg_wdata_i[MS_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_slot    <= SLOT_W'(RST_FIRST_SLOT);
      cfg_q.grace_ms      <= MS_W'(RST_GRACE_MS);
      cfg_q.quarantine_ms <= MS_W'(RST_QUARANTINE_MS);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/sard_ctrl.sv
// Sequencer of the slot allocator: clearing pass, free, first-fit scan.
`include "assert_macros.svh"

module sard_ctrl #(
  parameter int SLOT_COUNT = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sard_pkg::sard_cfg_t           cfg_i,
  input  logic                          start,
  output logic                          busy,
  input  sard_pkg::sard_in_t            item_i,
  output logic                          done_o,
  output sard_pkg::sard_out_t           result_o,
  output logic [$clog2(SLOT_COUNT)-1:0] mem_addr_o,
  output sard_pkg::sard_mem_ctl_t       mem_ctl_o,
  output logic [sard_pkg::TIME_W-1:0]   stamp_wd_o,
  input  logic                          busy_rd_i,
  input  logic [sard_pkg::TIME_W-1:0]   stamp_rd_i
);
  import sard_pkg::*;

  localparam int AddrW = $clog2(SLOT_COUNT);
  localparam int CntW  = $clog2(SLOT_COUNT + 1);
  localparam int CmpW  = (CntW > HW_W) ? CntW : HW_W;
  localparam int UsedRst = (RST_FIRST_SLOT < SLOT_COUNT) ? RST_FIRST_SLOT : SLOT_COUNT;
  localparam logic [CmpW-1:0]  SlotCnt  = CmpW'(SLOT_COUNT);
  localparam logic [CmpW-1:0]  LastSlot = CmpW'(SLOT_COUNT - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(SLOT_COUNT - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CmpW-1:0]   scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [CmpW-1:0]   pend_addr_q, pend_addr_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [CntW-1:0]   used_q, used_d;
  logic              done_q, done_d;
  sard_out_t         result_q, result_d;

  logic [CmpW-1:0]   first_ext, used_ext, idx_ext, cand, tgt;
  logic              hit;

  assign first_ext = CmpW'(cfg_i.first_slot);
  assign used_ext  = CmpW'(used_q);
  assign idx_ext   = CmpW'(item_i.slot_index);
  assign cand      = (first_ext > used_ext) ? first_ext : used_ext;

  // read data belongs to the slot addressed in the previous cycle
  assign hit = pend_q && !busy_rd_i &&
               ((stamp_rd_i < TIME_W'(cfg_i.grace_ms)) ||
                ((now_q - stamp_rd_i) > TIME_W'(cfg_i.quarantine_ms)));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    now_d       = now_q;
    used_d      = used_q;
    done_d      = 1'b0;
    result_d    = result_q;
    tgt         = cand;
    mem_addr_o  = scan_q[AddrW-1:0];
    mem_ctl_o   = '0;
    stamp_wd_o  = now_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_addr_o         = clr_q;
        mem_ctl_o.busy_we  = 1'b1;
        mem_ctl_o.stamp_we = 1'b1;
        stamp_wd_o         = '0;
        clr_d              = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (item_i.action == ACT_FREE) begin
            if (idx_ext < SlotCnt) begin
              mem_addr_o         = idx_ext[AddrW-1:0];
              mem_ctl_o.busy_we  = 1'b1;
              mem_ctl_o.stamp_we = 1'b1;
              stamp_wd_o         = item_i.now_ms;
            end
            done_d   = 1'b1;
            result_d = '{granted_slot: item_i.slot_index, table_full: 1'b0,
                         high_water: used_ext[HW_W-1:0]};
          end else begin
            scan_d  = first_ext;
            now_d   = item_i.now_ms;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_addr_o        = pend_addr_q[AddrW-1:0];
          mem_ctl_o.busy_we = 1'b1;
          mem_ctl_o.busy_wd = 1'b1;
          done_d            = 1'b1;
          result_d = '{granted_slot: pend_addr_q[SLOT_W-1:0], table_full: 1'b0,
                       high_water: used_ext[HW_W-1:0]};
          state_d  = ST_IDLE;
        end else if (scan_q < used_ext) begin
          pend_d      = 1'b1;
          pend_addr_d = scan_q;
          scan_d      = scan_q + 1'b1;
        end else begin
          // nothing reusable: take the slot at the mark (or first_slot if higher), or the last when full
          if (cand >= SlotCnt) begin
            tgt = LastSlot;
          end else begin
            used_d = CntW'(cand + 1'b1);
          end
          mem_addr_o        = tgt[AddrW-1:0];
          mem_ctl_o.busy_we = 1'b1;
          mem_ctl_o.busy_wd = 1'b1;
          done_d            = 1'b1;
          result_d = '{granted_slot: tgt[SLOT_W-1:0], table_full: (cand >= SlotCnt),
                       high_water: HW_W'(used_d)};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      used_q  <= CntW'(UsedRst);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    pend_addr_q <= pend_addr_d;
    now_q       <= now_d;
    result_q    <= result_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  `SARD_ASSERT_ALWAYS(a_used_bounded, clk_i, (!rst_ni || (used_q <= CntW'(SLOT_COUNT))))
  `SARD_ASSERT(a_scan_below_mark, clk_i, rst_ni, (pend_d |-> (scan_q < used_ext)))
  `SARD_ASSERT(a_mark_only_on_alloc, clk_i, rst_ni, ((state_q != ST_SCAN) |=> $stable(used_q)))
  `SARD_ASSERT(a_full_takes_last, clk_i, rst_ni,
    ((done_q && result_q.table_full) |-> (result_q.granted_slot == LastSlot[SLOT_W-1:0])))

endmodule

FILE: design/slot_allocator_with_reuse_delay_core.sv
// Slot allocator with reuse delay: top level with the slot memories.
//
// After reset the block runs a clearing pass over every slot of the slot
// memories with busy high; configuration writes are taken meanwhile.
// A beat is taken when start is high and busy is low. A free keeps busy
// low, so a new beat may follow at once. An allocate holds busy while it
// reads slots from first_slot upwards until a reusable one is found or the
// high-water mark is reached: the scan reads one slot per cycle through the
// single port of the memories. Each result is shown on result_o for one
// cycle, marked by done_o, in the cycle after its work ends; the receiver
// cannot stall it.
module slot_allocator_with_reuse_delay_core #(
  parameter int SLOT_COUNT = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  sard_pkg::sard_in_t              item_i,
  output logic                            done_o,
  output sard_pkg::sard_out_t             result_o,
  input  logic                            cfg_we_i,
  input  logic [sard_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sard_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sard_pkg::*;

  localparam int AddrW = $clog2(SLOT_COUNT);

  sard_cfg_t         cfg;
  sard_mem_ctl_t     mem_ctl;
  logic [AddrW-1:0]  mem_addr;
  logic [TIME_W-1:0] stamp_wd, stamp_rd;
  logic              busy_rd;

  sard_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sard_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .mem_addr_o (mem_addr),
    .mem_ctl_o  (mem_ctl),
    .stamp_wd_o (stamp_wd),
    .busy_rd_i  (busy_rd),
    .stamp_rd_i (stamp_rd)
  );

  // in-use bit per slot
  sard_ram #(
    .WIDTH (1),
    .DEPTH (SLOT_COUNT)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.busy_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_ctl.busy_wd),
    .rdata_o (busy_rd)
  );

  // time at which each slot was last freed
  sard_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOT_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.stamp_we),
    .addr_i  (mem_addr),
    .wdata_i (stamp_wd),
    .rdata_o (stamp_rd)
  );

endmodule
